// File: hw/rtl/tmr_pkg.sv
package tmr_pkg;

   // Sample queue geometry
   localparam int QUEUE_DEPTH = 100;
   localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int EST_W   = 24;
   localparam int COV_W   = 48;
   localparam int RHO_W   = 17;
   localparam int AGE_W   = 20;
   localparam int THR_W   = 16;
   localparam int ACCEL_W = 24;
   localparam int TIME_W  = 32;

   // Register reset values
   localparam logic [EST_W-1:0] EST_INIT_RST = 24'd2143027;
   localparam logic [RHO_W-1:0] RHO_RST      = 17'd65405;
   localparam logic [AGE_W-1:0] MIN_AGE_RST  = 20'd35000;
   localparam logic [AGE_W-1:0] MAX_AGE_RST  = 20'd45000;

   // Covariance after reset is one million in Q24.24
   localparam logic [COV_W-1:0] COV_RST  = 48'd1000000 << 24;
   localparam logic [48:0]      COV_MAX  = 49'h0_FFFF_FFFF_FFFF;
   localparam logic [48:0]      GAIN_MAX = 49'h0_8000_0000_0000;
   localparam logic [EST_W-1:0] EST_MAX  = '1;

   // Opcodes
   localparam logic [1:0] OP_COMMAND = 2'd0;
   localparam logic [1:0] OP_UPDATE  = 2'd1;
   localparam logic [1:0] OP_RESET   = 2'd2;

   // Status codes
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_UPDATED   = 2'd1;
   localparam logic [1:0] ST_TOO_RECENT = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   // Register indexes
   localparam logic [1:0] REG_INIT_EST = 2'd0;
   localparam logic [1:0] REG_RHO      = 2'd1;
   localparam logic [1:0] REG_MIN_AGE  = 2'd2;
   localparam logic [1:0] REG_MAX_AGE  = 2'd3;

   localparam int CSR_ADDR_W = 4;

   typedef struct packed {
      logic [1:0]                opcode;
      logic signed [ACCEL_W-1:0] accel_z;
      logic [TIME_W-1:0]         time_us;
   } req_type;

   typedef struct packed {
      logic signed [THR_W-1:0] throttle;
      logic [1:0]              status;
      logic [EST_W-1:0]        accel_per_throttle;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0]       stamp;
      logic signed [THR_W-1:0] throttle;
   } sample_type;

endpackage

// File: hw/rtl/thrust_map_rls_estimator_unit.sv
// Thrust map estimator: tracks vertical acceleration per unit throttle by scalar
// recursive least squares with forgetting, and turns desired accelerations into
// throttles. All products and quotients run on one 80-bit adder, used as a
// shift-add multiplier and a restoring divider, one bit per cycle, so one item
// is in flight at a time. A command item uses a 38-step divide; an update
// examines queued entries one at a time, and when the RLS step runs it adds
// five serial products and two divides of 94 and 84 steps; a reset or no-op
// item goes straight to the response. The block takes a new item while the
// previous result waits in the output register. The sample queue has no reset
// pass: only entries that the fill count covers are ever read.
module thrust_map_rls_estimator_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  tmr_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output tmr_pkg::rsp_type                   rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tmr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import tmr_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_THR, S_QWR, S_RD, S_CHK, S_T2, S_D, S_PT,
      S_K, S_TE, S_KI, S_P, S_RSP
   } state_type;

   localparam logic MODE_MUL = 1'b0;
   localparam logic MODE_DIV = 1'b1;

   // Control and item registers
   state_type               state_ff, state_in;
   logic [1:0]              op_ff, op_in;
   logic signed [ACCEL_W-1:0] accel_ff, accel_in;
   logic [TIME_W-1:0]       time_ff, time_in;
   logic signed [THR_W-1:0] thr_ff, thr_in;
   logic [1:0]              status_ff, status_in;
   logic [EST_W-1:0]        est_ff, est_in;
   logic [COV_W-1:0]        cov_ff, cov_in;
   logic [QIDX_W-1:0]       head_ff, head_in;
   logic [QCNT_W-1:0]       count_ff, count_in;
   logic [63:0]             d_ff, d_in;
   logic [47:0]             kmag_ff, kmag_in;
   logic                    neg_ff, neg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   // Configuration registers
   logic [EST_W-1:0]        init_est_ff, init_est_in;
   logic [RHO_W-1:0]        rho_ff, rho_in;
   logic [AGE_W-1:0]        min_age_ff, min_age_in;
   logic [AGE_W-1:0]        max_age_ff, max_age_in;

   // Shared arithmetic unit
   logic [79:0]             acc_ff, acc_in;
   logic [63:0]             num_ff, num_in;
   logic [63:0]             opnd_ff, opnd_in;
   logic [48:0]             quo_ff, quo_in;
   logic                    ovf_ff, ovf_in;
   logic [6:0]              cnt_ff, cnt_in;
   logic                    mode_ff, mode_in;

   // Queue memory
   sample_type              mem [QUEUE_DEPTH];
   sample_type              rd_ff;
   logic                    wr_en;
   logic [QIDX_W-1:0]       wr_addr;
   sample_type              wr_data;

   // Combinational helpers
   logic                    req_take;
   logic                    cfg_wr;
   logic [64:0]             r2;
   logic [79:0]             au_a, au_b, au_sum;
   logic                    au_cin;
   logic                    take;
   logic                    unit_done;
   logic [ACCEL_W-1:0]      amag;
   logic [15:0]             tm, tm_rd;
   logic [31:0]             age;
   logic [QIDX_W-1:0]       head_inc, head_adj;
   logic [QCNT_W-1:0]       count_adj;
   logic [QIDX_W:0]         slot_sum;
   logic [RHO_W-1:0]        rho_eff;
   logic signed [41:0]      a_sh, tprod, innov;
   logic [41:0]             innov_mag;
   logic [41:0]             delta;
   logic [42:0]             est_sum;
   logic                    q_big;

   assign req_take   = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;

   // Register read mux
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_INIT_EST: csr_prdata = 32'(init_est_ff);
         REG_RHO:      csr_prdata = 32'(rho_ff);
         REG_MIN_AGE:  csr_prdata = 32'(min_age_ff);
         REG_MAX_AGE:  csr_prdata = 32'(max_age_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // One adder: shift-add for products, trial subtract for quotients
   assign r2 = {acc_ff[63:0], num_ff[63]};
   always_comb begin
      if (mode_ff == MODE_MUL) begin
         au_a   = {acc_ff[78:0], 1'b0};
         au_b   = num_ff[63] ? {16'b0, opnd_ff} : '0;
         au_cin = 1'b0;
      end else begin
         au_a   = {15'b0, r2};
         au_b   = ~{16'b0, opnd_ff};
         au_cin = 1'b1;
      end
   end
   assign au_sum    = au_a + au_b + 80'(au_cin);
   assign take      = !au_sum[79];
   assign unit_done = (cnt_ff == '0);

   assign amag     = req_data.accel_z[ACCEL_W-1] ? (~req_data.accel_z + 1'b1)
                                                 : req_data.accel_z;
   assign tm       = thr_ff[THR_W-1] ? 16'(-thr_ff) : 16'(thr_ff);
   assign tm_rd    = rd_ff.throttle[THR_W-1] ? 16'(-rd_ff.throttle) : 16'(rd_ff.throttle);
   assign age      = time_ff - rd_ff.stamp;
   assign head_inc = (head_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign rho_eff  = (rho_ff == '0) ? RHO_W'(1) : rho_ff;
   assign q_big    = ovf_ff || (quo_ff > 49'(GAIN_MAX));

   // Queue slot for a new sample, dropping the oldest when full
   always_comb begin
      if (count_ff >= QCNT_W'(QUEUE_DEPTH)) begin
         head_adj  = head_inc;
         count_adj = QCNT_W'(QUEUE_DEPTH - 1);
      end else begin
         head_adj  = head_ff;
         count_adj = count_ff;
      end
      slot_sum = (QIDX_W+1)'(head_adj) + (QIDX_W+1)'(count_adj);
      if (slot_sum >= (QIDX_W+1)'(QUEUE_DEPTH))
         slot_sum = slot_sum - (QIDX_W+1)'(QUEUE_DEPTH);
   end

   // Innovation and estimate step
   assign a_sh      = {{4{accel_ff[ACCEL_W-1]}}, accel_ff, 14'b0};
   assign tprod     = thr_ff[THR_W-1] ? -$signed({2'b0, acc_ff[39:0]})
                                      : $signed({2'b0, acc_ff[39:0]});
   assign innov     = a_sh - tprod;
   assign innov_mag = innov[41] ? 42'(-innov) : 42'(innov);
   assign delta     = (thr_ff == '0) ? '0 : acc_ff[73:32];
   assign est_sum   = 43'(est_ff) + 43'(delta);

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      accel_in     = accel_ff;
      time_in      = time_ff;
      thr_in       = thr_ff;
      status_in    = status_ff;
      est_in       = est_ff;
      cov_in       = cov_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      d_in         = d_ff;
      kmag_in      = kmag_ff;
      neg_in       = neg_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      init_est_in  = init_est_ff;
      rho_in       = rho_ff;
      min_age_in   = min_age_ff;
      max_age_in   = max_age_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_sum[QIDX_W-1:0];
      wr_data      = '{stamp: time_ff, throttle: thr_ff};

      // advance the shared unit one bit
      acc_in  = acc_ff;
      num_in  = num_ff;
      opnd_in = opnd_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      mode_in = mode_ff;
      if (!unit_done) begin
         cnt_in = cnt_ff - 1'b1;
         num_in = {num_ff[62:0], 1'b0};
         if (mode_ff == MODE_MUL) begin
            acc_in = au_sum;
         end else begin
            acc_in = take ? {16'b0, au_sum[63:0]} : {16'b0, r2[63:0]};
            quo_in = {quo_ff[47:0], take};
            ovf_in = ovf_ff | quo_ff[48];
         end
      end

      // configuration writes
      if (cfg_wr) begin
         unique case (csr_paddr[3:2])
            REG_INIT_EST: init_est_in = csr_pwdata[EST_W-1:0];
            REG_RHO:      rho_in      = csr_pwdata[RHO_W-1:0];
            REG_MIN_AGE:  min_age_in  = csr_pwdata[AGE_W-1:0];
            REG_MAX_AGE:  max_age_in  = csr_pwdata[AGE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in     = req_data.opcode;
               accel_in  = req_data.accel_z;
               time_in   = req_data.time_us;
               thr_in    = '0;
               status_in = ST_DONE;
               unique case (req_data.opcode)
                  OP_COMMAND: begin
                     if (est_ff == '0) begin
                        if (req_data.accel_z == '0)
                           thr_in = '0;
                        else if (req_data.accel_z[ACCEL_W-1])
                           thr_in = 16'sh8000;
                        else
                           thr_in = 16'sh7FFF;
                        state_in = S_QWR;
                     end else begin
                        acc_in   = '0;
                        quo_in   = '0;
                        ovf_in   = 1'b0;
                        num_in   = {amag, 40'b0};
                        opnd_in  = 64'(est_ff);
                        cnt_in   = 7'd38;
                        mode_in  = MODE_DIV;
                        state_in = S_THR;
                     end
                  end
                  OP_UPDATE: begin
                     status_in = ST_EMPTY;
                     state_in  = S_RD;
                  end
                  OP_RESET: begin
                     est_in   = init_est_ff;
                     cov_in   = COV_RST;
                     state_in = S_RSP;
                  end
                  default: state_in = S_RSP;
               endcase
            end
         end
         S_THR: begin
            if (unit_done) begin
               if (accel_ff[ACCEL_W-1])
                  thr_in = (ovf_ff || quo_ff >= 49'd32768) ? 16'sh8000
                                                           : -$signed(quo_ff[15:0]);
               else
                  thr_in = (ovf_ff || quo_ff >= 49'd32767) ? 16'sh7FFF
                                                           : $signed(quo_ff[15:0]);
               state_in = S_QWR;
            end
         end
         S_QWR: begin
            wr_en    = 1'b1;
            head_in  = head_adj;
            count_in = count_adj + 1'b1;
            state_in = S_RSP;
         end
         S_RD: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
               state_in  = S_RSP;
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            priority if (age > 32'(max_age_ff)) begin
               // drop a stale entry and look at the next
               head_in  = head_inc;
               count_in = count_ff - 1'b1;
               state_in = S_RD;
            end else if (age < 32'(min_age_ff)) begin
               status_in = ST_TOO_RECENT;
               state_in  = S_RSP;
            end else begin
               head_in   = head_inc;
               count_in  = count_ff - 1'b1;
               thr_in    = rd_ff.throttle;
               status_in = ST_UPDATED;
               acc_in    = '0;
               num_in    = {tm_rd, 48'b0};
               opnd_in   = 64'(tm_rd);
               cnt_in    = 7'd16;
               mode_in   = MODE_MUL;
               state_in  = S_T2;
            end
         end
         S_T2: begin
            if (unit_done) begin
               acc_in   = '0;
               num_in   = {acc_ff[30:0], 33'b0};
               opnd_in  = 64'(cov_ff);
               cnt_in   = 7'd31;
               state_in = S_D;
            end
         end
         S_D: begin
            if (unit_done) begin
               d_in     = {rho_eff, 20'b0} + {1'b0, acc_ff[78:16]};
               acc_in   = '0;
               num_in   = {tm, 48'b0};
               opnd_in  = 64'(cov_ff);
               cnt_in   = 7'd16;
               state_in = S_PT;
            end
         end
         S_PT: begin
            if (unit_done) begin
               acc_in   = '0;
               quo_in   = '0;
               ovf_in   = 1'b0;
               num_in   = acc_ff[63:0];
               opnd_in  = d_ff;
               cnt_in   = 7'd94;
               mode_in  = MODE_DIV;
               state_in = S_K;
            end
         end
         S_K: begin
            if (unit_done) begin
               kmag_in  = q_big ? GAIN_MAX[47:0] : quo_ff[47:0];
               acc_in   = '0;
               num_in   = {tm, 48'b0};
               opnd_in  = 64'(est_ff);
               cnt_in   = 7'd16;
               mode_in  = MODE_MUL;
               state_in = S_TE;
            end
         end
         S_TE: begin
            if (unit_done) begin
               neg_in   = innov[41] ^ thr_ff[THR_W-1];
               acc_in   = '0;
               num_in   = {innov_mag[39:14], 38'b0};
               opnd_in  = 64'(kmag_ff);
               cnt_in   = 7'd26;
               state_in = S_KI;
            end
         end
         S_KI: begin
            if (unit_done) begin
               if (neg_ff)
                  est_in = (delta >= 42'(est_ff)) ? '0 : est_ff - delta[EST_W-1:0];
               else
                  est_in = (est_sum > 43'(EST_MAX)) ? EST_MAX : est_sum[EST_W-1:0];
               acc_in   = '0;
               quo_in   = '0;
               ovf_in   = 1'b0;
               num_in   = {cov_ff, 16'b0};
               opnd_in  = d_ff;
               cnt_in   = 7'd84;
               mode_in  = MODE_DIV;
               state_in = S_P;
            end
         end
         S_P: begin
            if (unit_done) begin
               cov_in   = (ovf_ff || quo_ff > COV_MAX) ? COV_MAX[47:0] : quo_ff[47:0];
               state_in = S_RSP;
            end
         end
         S_RSP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.throttle           = (op_ff == OP_COMMAND) ? thr_ff : '0;
               rsp_data_in.status             = status_ff;
               rsp_data_in.accel_per_throttle = est_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         est_ff       <= EST_INIT_RST;
         cov_ff       <= COV_RST;
         head_ff      <= '0;
         count_ff     <= '0;
         cnt_ff       <= '0;
         init_est_ff  <= EST_INIT_RST;
         rho_ff       <= RHO_RST;
         min_age_ff   <= MIN_AGE_RST;
         max_age_ff   <= MAX_AGE_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         est_ff       <= est_in;
         cov_ff       <= cov_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         cnt_ff       <= cnt_in;
         init_est_ff  <= init_est_in;
         rho_ff       <= rho_in;
         min_age_ff   <= min_age_in;
         max_age_ff   <= max_age_in;
      end
      op_ff       <= op_in;
      accel_ff    <= accel_in;
      time_ff     <= time_in;
      thr_ff      <= thr_in;
      status_ff   <= status_in;
      d_ff        <= d_in;
      kmag_ff     <= kmag_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
      acc_ff      <= acc_in;
      num_ff      <= num_in;
      opnd_ff     <= opnd_in;
      quo_ff      <= quo_in;
      ovf_ff      <= ovf_in;
      mode_ff     <= mode_in;
   end

   // Sample queue: write on record, read the front every cycle
   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      rd_ff <= mem[head_ff];
   end

endmodule

// File: sim/thrust_map_rls_estimator_unit_tb.sv
module thrust_map_rls_estimator_unit_tb;
   import tmr_pkg::*;

   localparam logic [1:0] OP_NOOP = 2'd3;
   localparam longint CYCLE_LIMIT = 4000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   thrust_map_rls_estimator_unit DUT (.*);

   always #5 clock = ~clock;

   // Register mirror
   logic [EST_W-1:0] cfg_init_est = EST_INIT_RST;
   logic [RHO_W-1:0] cfg_rho = RHO_RST;
   logic [AGE_W-1:0] cfg_min_age = MIN_AGE_RST;
   logic [AGE_W-1:0] cfg_max_age = MAX_AGE_RST;

   // Estimator state mirror
   logic [TIME_W-1:0] stamp_mem [QUEUE_DEPTH];
   logic signed [THR_W-1:0] thr_mem [QUEUE_DEPTH];
   int unsigned fifo_head = 0;
   int unsigned fifo_count = 0;
   logic [63:0] est_now = 64'(EST_INIT_RST);
   logic [63:0] cov_now = 64'(COV_RST);

   req_type pending_items[$];
   rsp_type expected_rsps[$];
   int mismatch_count = 0;
   int rsp_count = 0;
   longint cycle_count = 0;
   logic req_fire = 1'b0;
   int send_gap = 0;
   int stall_left = 0;
   int hold_left = 0;
   bit send_quiet = 0;
   bit recv_quiet = 0;
   bit hold_a_done = 0;
   bit hold_b_done = 0;
   logic [TIME_W-1:0] stamp_now = 32'd1000;

   // floor(a * 2^s / d), clamped to lim; zero divisor gives lim
   function automatic logic [63:0] div_clamp(logic [63:0] a, int s, logic [63:0] d,
                                             logic [63:0] lim);
      logic [127:0] q;
      if (d == 0) return lim;
      q = ({64'd0, a} << s) / {64'd0, d};
      return (q > {64'd0, lim}) ? lim : q[63:0];
   endfunction

   // One RLS step on estimate and covariance
   function automatic void rls_step(logic signed [THR_W-1:0] thr, longint accel);
      logic [63:0] rho, tmag, t2, d, kmag, imag;
      logic [127:0] delta;
      longint t, innov;
      bit neg;
      rho = (cfg_rho == 0) ? 64'd1 : 64'(cfg_rho);
      t = longint'(thr);
      tmag = (t < 0) ? 64'(-t) : 64'(t);
      t2 = tmag * tmag;
      d = (rho << 20) + t2 * (cov_now >> 16) + ((t2 * (cov_now & 64'hFFFF)) >> 16);
      kmag = div_clamp(cov_now * tmag, 30, d, 64'(GAIN_MAX));
      innov = accel * 16384 - t * longint'(est_now);
      neg = (innov < 0) != (t < 0);
      imag = ((innov < 0) ? 64'(-innov) : 64'(innov)) >> 14;
      delta = ({64'd0, kmag} * {64'd0, imag}) >> 32;
      if (t == 0) delta = 0;
      if (neg)
         est_now = (delta >= {64'd0, est_now}) ? 64'd0 : est_now - delta[63:0];
      else if ({64'd0, est_now} + delta > 128'(EST_MAX))
         est_now = 64'(EST_MAX);
      else
         est_now = est_now + delta[63:0];
      cov_now = div_clamp(cov_now, 36, d, 64'(COV_MAX));
   endfunction

   // Work out the result of one accepted item and queue it
   function automatic void predict_estimator(req_type r);
      rsp_type res;
      longint accel;
      logic [63:0] amag, q;
      logic signed [THR_W-1:0] thr;
      logic [31:0] age;
      int unsigned slot;
      accel = longint'(r.accel_z);
      thr = '0;
      res = '0;
      res.status = ST_DONE;
      case (r.opcode)
         OP_COMMAND: begin
            amag = (accel < 0) ? 64'(-accel) : 64'(accel);
            if (est_now == 0) q = (amag != 0) ? 64'd32768 : 64'd0;
            else q = (amag << 14) / est_now;
            if (accel < 0) thr = (q >= 32768) ? -16'sd32768 : -16'(q);
            else thr = (q >= 32767) ? 16'sd32767 : 16'(q);
            if (fifo_count >= QUEUE_DEPTH) begin
               fifo_head = (fifo_head + 1) % QUEUE_DEPTH;
               fifo_count = QUEUE_DEPTH - 1;
            end
            slot = (fifo_head + fifo_count) % QUEUE_DEPTH;
            stamp_mem[slot] = r.time_us;
            thr_mem[slot] = thr;
            fifo_count++;
         end
         OP_UPDATE: begin
            res.status = ST_EMPTY;
            while (fifo_count > 0) begin
               age = r.time_us - stamp_mem[fifo_head];
               if (age > 32'(cfg_max_age)) begin
                  fifo_head = (fifo_head + 1) % QUEUE_DEPTH;
                  fifo_count--;
                  continue;
               end
               if (age < 32'(cfg_min_age)) begin
                  res.status = ST_TOO_RECENT;
                  break;
               end
               slot = fifo_head;
               fifo_head = (fifo_head + 1) % QUEUE_DEPTH;
               fifo_count--;
               rls_step(thr_mem[slot], accel);
               res.status = ST_UPDATED;
               break;
            end
         end
         OP_RESET: begin
            est_now = 64'(cfg_init_est);
            cov_now = 64'(COV_RST);
         end
         default: ;
      endcase
      res.throttle = thr;
      res.accel_per_throttle = est_now[EST_W-1:0];
      expected_rsps.push_back(res);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch on result %0d: %s got %0h want %0h", rsp_count, field, got, want);
      mismatch_count++;
   endtask

   // Count cycles, catch input acceptance and feed the predictor
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         req_fire <= !reset && req_valid && !req_stall;
         if (!reset && req_valid && !req_stall) predict_estimator(req_data);
      end
   end

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("unexpected result %0d: %h", rsp_count, rsp_data);
            mismatch_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.throttle !== want.throttle)
               report_mismatch("throttle", 32'(rsp_data.throttle), 32'(want.throttle));
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            if (rsp_data.accel_per_throttle !== want.accel_per_throttle)
               report_mismatch("accel_per_throttle", 32'(rsp_data.accel_per_throttle),
                               32'(want.accel_per_throttle));
         end
         rsp_count++;
      end
   end

   // Drive items: hold a stalled item, otherwise advance after a random gap
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_fire)) begin
         if ($urandom_range(0, 149) == 0) send_quiet = !send_quiet;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_data <= pending_items.pop_front();
            req_valid <= 1'b1;
            send_gap = send_quiet ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall results at random, with two long holds to back up the input
   always @(negedge clock) begin
      if (!hold_a_done && rsp_count >= 150) begin
         hold_a_done = 1;
         hold_left = 400;
      end else if (!hold_b_done && rsp_count >= 800) begin
         hold_b_done = 1;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         if ($urandom_range(0, 149) == 0) recv_quiet = !recv_quiet;
         stall_left = recv_quiet ? 0 : pick_gap();
         rsp_stall <= (stall_left > 0);
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_INIT_EST: cfg_init_est = val[EST_W-1:0];
         REG_RHO:      cfg_rho = val[RHO_W-1:0];
         REG_MIN_AGE:  cfg_min_age = val[AGE_W-1:0];
         REG_MAX_AGE:  cfg_max_age = val[AGE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic push_item(logic [1:0] op, logic [23:0] accel, logic [31:0] stamp);
      req_type r;
      r.opcode = op;
      r.accel_z = accel;
      r.time_us = stamp;
      pending_items.push_back(r);
   endtask

   // Wait until every queued item is sent and every expected result has come
   task automatic drain();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [23:0] rand_accel();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 24'h7FFFFF;
      if (r == 1) return 24'h800000;
      if (r < 4) return 24'($urandom);
      return 24'($urandom_range(0, 2000000)) - 24'd300000;
   endfunction

   // Mostly control-loop traffic: commands, updates a few frames later
   task automatic random_phase(int n);
      int i, r, k, span;
      span = ((cfg_max_age > cfg_min_age) ? int'(cfg_max_age) : int'(cfg_min_age)) / 6 + 1000;
      i = 0;
      while (i < n) begin
         r = $urandom_range(0, 999);
         if ($urandom_range(0, 99) < 2) stamp_now = $urandom;
         else stamp_now += $urandom_range(0, span);
         if (r < 3) begin
            k = $urandom_range(100, 115);
            repeat (k) begin
               stamp_now += $urandom_range(0, span);
               push_item(OP_COMMAND, rand_accel(), stamp_now);
            end
            i += k;
         end else begin
            if (r < 460) push_item(OP_COMMAND, rand_accel(), stamp_now);
            else if (r < 900) push_item(OP_UPDATE, rand_accel(), stamp_now);
            else if (r < 950) push_item(OP_RESET, rand_accel(), stamp_now);
            else push_item(OP_NOOP, rand_accel(), stamp_now);
            i++;
         end
      end
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty queue, extremes, too recent, update, stale, wrap
      push_item(OP_RESET, 24'd0, 32'd0);
      push_item(OP_NOOP, 24'h7FFFFF, 32'hFFFFFFFF);
      push_item(OP_UPDATE, 24'h123456, 32'd100);
      push_item(OP_COMMAND, 24'h7FFFFF, 32'd1000);
      push_item(OP_COMMAND, 24'h800000, 32'd2000);
      push_item(OP_COMMAND, 24'd0, 32'd3000);
      push_item(OP_COMMAND, 24'd642252, 32'd4000);
      push_item(OP_UPDATE, 24'd600000, 32'd5000);
      push_item(OP_UPDATE, 24'd700000, 32'd41000);
      push_item(OP_UPDATE, 24'h800000, 32'd42000);
      push_item(OP_UPDATE, 24'h7FFFFF, 32'd43500);
      push_item(OP_UPDATE, 24'd650000, 32'd44000);
      push_item(OP_COMMAND, 24'd500000, 32'd50000);
      push_item(OP_UPDATE, 24'd500000, 32'd2000000);
      push_item(OP_COMMAND, 24'hFFF000, 32'hFFFFFF00);
      push_item(OP_COMMAND, 24'd800000, 32'h00000100);
      push_item(OP_UPDATE, 24'd900000, 32'd39744);
      push_item(OP_UPDATE, 24'd100000, 32'd40000);
      push_item(OP_RESET, 24'd0, 32'd40001);
      drain();

      random_phase(220);

      csr_write(REG_INIT_EST, 32'd16777215);
      csr_write(REG_RHO, 32'd65536);
      csr_write(REG_MIN_AGE, 32'd0);
      csr_write(REG_MAX_AGE, 32'd1000000);
      push_item(OP_RESET, 24'd0, stamp_now);
      random_phase(220);

      // Zero estimate, zero forgetting factor, min age above max age
      csr_write(REG_INIT_EST, 32'd0);
      csr_write(REG_RHO, 32'd0);
      csr_write(REG_MIN_AGE, 32'd1000000);
      csr_write(REG_MAX_AGE, 32'd0);
      push_item(OP_RESET, 24'd0, stamp_now);
      push_item(OP_COMMAND, 24'd5, stamp_now);
      push_item(OP_COMMAND, 24'hFFFFFB, stamp_now);
      push_item(OP_COMMAND, 24'd0, stamp_now);
      random_phase(180);

      csr_write(REG_INIT_EST, 32'd1);
      csr_write(REG_RHO, 32'd1);
      csr_write(REG_MIN_AGE, 32'd20000);
      csr_write(REG_MAX_AGE, 32'd60000);
      push_item(OP_RESET, 24'd0, stamp_now);
      random_phase(220);

      csr_write(REG_INIT_EST, 32'd655360);
      csr_write(REG_RHO, 32'd32768);
      csr_write(REG_MIN_AGE, 32'hFFFFF);
      csr_write(REG_MAX_AGE, 32'hFFFFF);
      random_phase(150);

      csr_write(REG_INIT_EST, 32'(EST_INIT_RST));
      csr_write(REG_RHO, 32'(RHO_RST));
      csr_write(REG_MIN_AGE, 32'(MIN_AGE_RST));
      csr_write(REG_MAX_AGE, 32'(MAX_AGE_RST));
      push_item(OP_RESET, 24'd0, stamp_now);
      random_phase(200);

      csr_write(REG_INIT_EST, $urandom_range(1000000, 4000000));
      csr_write(REG_RHO, $urandom_range(60000, 65536));
      csr_write(REG_MIN_AGE, $urandom_range(5000, 30000));
      csr_write(REG_MAX_AGE, $urandom_range(30000, 90000));
      random_phase(150);

      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
